/* rtl/core/rs485_rx_pkg.sv */
// ----------------------------------------------------------------------------
// RS-485 frame receiver package
// Word types, command codes, register indexes and frame constants shared by
// the frame receiver.
// ----------------------------------------------------------------------------
package rs485_rx_pkg;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [1:0] CFG_FILTER_EN  = 2'd0;
    localparam logic [1:0] CFG_OWN_SERIAL = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [7:0]  START_MARK    = 8'h79;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [8:0] byte_pos;
        logic       in_frame;
        logic       header_error;
        logic       frame_done;
        logic       frame_accept;
        logic       checksum_error;
        logic       address_mismatch;
        logic       timeout_abort;
    } t_out_word;

endpackage

/* rtl/core/rs485_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// RS-485 frame receiver
// Each input word is one received byte or one timer tick. The block takes
// one word per clock cycle unless the output stalls, and returns one result
// word for it in the next cycle; a new word is taken in the same cycle in
// which the previous result leaves the output register. This rate is set by
// the update of the parser state (position, running sum and address
// compare), which is done at the moment a word is accepted.
// ----------------------------------------------------------------------------
module rs485_frame_receiver_top
    import rs485_rx_pkg::*;
#(
    parameter int ADDR_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [8:0] POS_SECOND_MARK = 9'(ADDR_BYTES + 1);
    localparam logic [8:0] POS_LENGTH      = 9'(ADDR_BYTES + 3);
    localparam logic [8:0] OFFS_CHECKSUM   = 9'(ADDR_BYTES + 4);
    localparam logic [8:0] OFFS_TRAILER    = 9'(ADDR_BYTES + 5);
    localparam logic [8:0] ADDR_LAST       = 9'(ADDR_BYTES);

    logic        r_filter_en;
    logic [63:0] r_own_serial;
    logic [15:0] r_timeout;

    logic        r_collecting;
    logic [8:0]  r_frame_index;
    logic [7:0]  r_payload_len;
    logic [7:0]  r_running_sum;
    logic [7:0]  r_checksum;
    logic        r_addr_equal;
    logic [15:0] r_idle_ticks;

    logic        n_collecting;
    logic [8:0]  n_frame_index;
    logic [7:0]  n_payload_len;
    logic [7:0]  n_running_sum;
    logic [7:0]  n_checksum;
    logic        n_addr_equal;
    logic [15:0] n_idle_ticks;

    logic        r_out_valid;
    t_out_word   r_out;
    t_out_word   n_out;

    logic        accept;
    logic        do_restart;
    logic [15:0] limit;
    logic [15:0] idle_inc;
    logic [8:0]  pos_checksum;
    logic [8:0]  pos_trailer;
    logic [8:0]  addr_shift;
    logic [7:0]  addr_want;
    logic [7:0]  rx;
    logic        sum_ok;
    logic        addr_ok;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign rx           = i_in_word.rx_byte;
    assign limit        = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign idle_inc     = r_idle_ticks + 16'd1;
    assign pos_checksum = 9'(r_payload_len) + OFFS_CHECKSUM;
    assign pos_trailer  = 9'(r_payload_len) + OFFS_TRAILER;
    assign addr_shift   = ADDR_LAST - r_frame_index;
    assign addr_want    = r_own_serial[8 * addr_shift[2:0] +: 8];
    assign sum_ok       = (r_running_sum == r_checksum);
    assign addr_ok      = !r_filter_en || r_addr_equal;

    always_comb begin
        n_collecting  = r_collecting;
        n_frame_index = r_frame_index;
        n_payload_len = r_payload_len;
        n_running_sum = r_running_sum;
        n_checksum    = r_checksum;
        n_addr_equal  = r_addr_equal;
        n_idle_ticks  = r_idle_ticks;
        n_out         = '0;
        do_restart    = 1'b0;

        if (i_in_word.cmd == CMD_TICK) begin
            if (r_frame_index != 9'd0) begin
                n_idle_ticks = idle_inc;
                if (idle_inc >= limit) begin
                    do_restart          = 1'b1;
                    n_out.timeout_abort = 1'b1;
                end
            end
        end else begin
            n_out.out_byte = rx;
            n_out.byte_pos = r_frame_index;
            n_idle_ticks   = 16'd0;
            if (!r_collecting) begin
                if (r_frame_index == 9'd0) begin
                    if (rx == START_MARK) begin
                        n_running_sum  = rx;
                        n_addr_equal   = 1'b1;
                        n_frame_index  = 9'd1;
                        n_out.in_frame = 1'b1;
                    end else begin
                        n_out.header_error = 1'b1;
                    end
                end else if (r_frame_index == POS_SECOND_MARK) begin
                    if (rx == START_MARK) begin
                        n_running_sum  = r_running_sum + rx;
                        n_collecting   = 1'b1;
                        n_frame_index  = r_frame_index + 9'd1;
                        n_out.in_frame = 1'b1;
                    end else begin
                        do_restart         = 1'b1;
                        n_out.header_error = 1'b1;
                    end
                end else begin
                    if (addr_want != rx) begin
                        n_addr_equal = 1'b0;
                    end
                    n_running_sum  = r_running_sum + rx;
                    n_frame_index  = r_frame_index + 9'd1;
                    n_out.in_frame = 1'b1;
                end
            end else begin
                n_out.in_frame = 1'b1;
                if (r_frame_index == POS_LENGTH) begin
                    n_payload_len = rx;
                    n_running_sum = r_running_sum + rx;
                    n_frame_index = r_frame_index + 9'd1;
                end else if (r_frame_index == pos_trailer) begin
                    n_out.frame_done       = 1'b1;
                    n_out.frame_accept     = sum_ok && addr_ok;
                    n_out.checksum_error   = !sum_ok;
                    n_out.address_mismatch = sum_ok && !addr_ok;
                    do_restart             = 1'b1;
                end else begin
                    if (r_frame_index < pos_checksum) begin
                        n_running_sum = r_running_sum + rx;
                    end else if (r_frame_index == pos_checksum) begin
                        n_checksum = rx;
                    end
                    n_frame_index = r_frame_index + 9'd1;
                end
            end
        end

        if (do_restart) begin
            n_collecting  = 1'b0;
            n_frame_index = 9'd0;
            n_payload_len = 8'd0;
            n_running_sum = 8'd0;
            n_checksum    = 8'd0;
            n_addr_equal  = 1'b1;
            n_idle_ticks  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en  <= 1'b0;
            r_own_serial <= 64'd0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_EN:  r_filter_en  <= i_cfg_data[0];
                CFG_OWN_SERIAL: r_own_serial <= i_cfg_data;
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting  <= 1'b0;
            r_frame_index <= 9'd0;
            r_payload_len <= 8'd0;
            r_running_sum <= 8'd0;
            r_checksum    <= 8'd0;
            r_addr_equal  <= 1'b1;
            r_idle_ticks  <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_collecting  <= n_collecting;
                r_frame_index <= n_frame_index;
                r_payload_len <= n_payload_len;
                r_running_sum <= n_running_sum;
                r_checksum    <= n_checksum;
                r_addr_equal  <= n_addr_equal;
                r_idle_ticks  <= n_idle_ticks;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // A completed frame carries exactly one verdict.
    a_done_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |->
            $onehot({r_out.frame_accept, r_out.checksum_error, r_out.address_mismatch}))
        else $error("completed frame without exactly one verdict");

    // No verdict is given on a word that does not complete a frame.
    a_no_stray_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_done) |->
            !(r_out.frame_accept || r_out.checksum_error || r_out.address_mismatch))
        else $error("verdict flag on a word that did not complete a frame");

    // The body is only collected after both start marks.
    a_body_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_frame_index > POS_SECOND_MARK))
        else $error("body collection at a header position");

    // A timeout or a completed frame leaves the parser at the frame start.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (n_out.timeout_abort || n_out.frame_done)) |=>
            (r_frame_index == 9'd0 && !r_collecting && r_idle_ticks == 16'd0))
        else $error("parser not restarted after frame end or timeout");

endmodule
